@@ rtl/lkvc_pkg.sv @@
// Package for the LRU key/value cache: operation codes, field widths and constants.
// Used by the cache top level and by its port checker; depends on nothing.
`default_nettype none

package lkvc_pkg;

   // Field widths fixed by the item format
   localparam int DATA_W = 32;
   localparam int CSR_W  = 5;

   // Operation codes carried in the item
   localparam logic OP_GET = 1'b0;
   localparam logic OP_ADD = 1'b1;

   // Value returned on a get miss and for every add
   localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

   // Capacity after reset
   localparam logic [CSR_W-1:0] CAPACITY_RESET = 5'd16;

   // One item held in the input register
   typedef struct packed {
      logic                     operation;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value_in;
   } req_item_type;

endpackage

`default_nettype wire

@@ rtl/lru_key_value_cache_unit.sv @@
// Top level of the LRU key/value cache: input register, parallel lookup and
// rank update, result register. Depends on lkvc_pkg.
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// One item is accepted per cycle unless stalled; it passes the input register,
// then the result register. The match, the rank update and the slot choice all
// happen in one pass between those two registers, so each new item always sees
// the store as left by the item before it. req_stall rises only while the input
// register holds an item and the result register is full and stalled. The user
// must write capacity through csr_wr_en/csr_wr_data only while the cache is idle;
// the block does not enforce it. Zero acts as one and values above ENTRIES as
// ENTRIES. Reset clears all entries at once; no clearing pass is needed.
module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // configuration
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_W-1:0]         csr_wr_data,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_operation,
   input  wire logic signed [DATA_W-1:0] req_key,
   input  wire logic signed [DATA_W-1:0] req_value_in,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_found,
   output logic signed [DATA_W-1:0]      rsp_value_out
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   // Configuration
   logic [CSR_W-1:0] capacity_ff;

   // Input stage
   logic         s1_valid_ff;
   req_item_type s1_item_ff;

   // Result stage
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;

   // Store
   logic signed [DATA_W-1:0] key_ff   [ENTRIES];
   logic signed [DATA_W-1:0] value_ff [ENTRIES];
   logic [RANK_W-1:0]        rank_ff  [ENTRIES];
   logic [RANK_W-1:0]        rank_in  [ENTRIES];
   logic [ENTRIES-1:0]       valid_ff;
   logic [ENTRIES-1:0]       valid_in;
   logic [CNT_W-1:0]         occupancy_ff;
   logic [CNT_W-1:0]         occupancy_in;

   // Single-pass lookup signals
   logic                     out_free;
   logic                     fire;
   logic [ENTRIES-1:0]       hit_vec;
   logic                     hit;
   logic signed [DATA_W-1:0] hit_value;
   logic [RANK_W-1:0]        hit_rank;
   logic [CMP_W-1:0]         eff_cap;
   logic                     evict;
   logic [CNT_W-1:0]         occ_dec;
   logic [ENTRIES-1:0]       victim_vec;
   logic [ENTRIES-1:0]       free_vec;
   logic [ENTRIES-1:0]       slot_vec;
   logic                     is_add;
   logic                     do_insert;
   logic [ENTRIES-1:0]       write_vec;

   // Handshake: the input stage moves on when the result register can take it
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_value_out = rsp_value_ff;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_item_ff.operation <= req_operation;
         s1_item_ff.key       <= req_key;
         s1_item_ff.value_in  <= req_value_in;
      end
   end

   // Parallel key match; keys are unique among valid entries
   always_comb begin
      hit_value = '0;
      hit_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == s1_item_ff.key);
         hit_value  = hit_value | (key_ff[i] == s1_item_ff.key && valid_ff[i] ?
                                   value_ff[i] : '0);
         hit_rank   = hit_rank | (hit_vec[i] ? rank_ff[i] : '0);
      end
      hit = |hit_vec;
   end

   // Effective capacity: zero acts as one, saturate at the entry count
   always_comb begin
      eff_cap = CMP_W'(capacity_ff);
      if (eff_cap == '0) begin
         eff_cap = CMP_W'(1);
      end else if (eff_cap > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end
   end

   // Slot choice: the least recent entry holds rank occupancy-1,
   // otherwise take the lowest free slot
   assign evict    = CMP_W'(occupancy_ff) >= eff_cap;
   assign occ_dec  = occupancy_ff - CNT_W'(1);
   assign free_vec = ~valid_ff & (valid_ff + ENTRIES'(1));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == occ_dec[RANK_W-1:0]);
      end
   end

   assign slot_vec  = evict ? victim_vec : free_vec;
   assign is_add    = (s1_item_ff.operation == OP_ADD);
   assign do_insert = is_add && !hit;
   assign write_vec = do_insert ? slot_vec : (is_add ? hit_vec : '0);

   // Next ranks, valid marks and occupancy
   always_comb begin
      valid_in     = valid_ff;
      occupancy_in = occupancy_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (hit) begin
         // touch: entries more recent than the hit age by one
         for (int i = 0; i < ENTRIES; i++) begin
            if (hit_vec[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end else if (do_insert) begin
         // insert: every other valid entry ages by one
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_vec[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         valid_in = valid_ff | slot_vec;
         if (!evict) begin
            occupancy_in = occupancy_ff + CNT_W'(1);
         end
      end
   end

   // Store control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occupancy_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (fire) begin
         valid_ff     <= valid_in;
         occupancy_ff <= occupancy_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (write_vec[i]) begin
               key_ff[i]   <= s1_item_ff.key;
               value_ff[i] <= s1_item_ff.value_in;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_found_ff <= hit;
         rsp_value_ff <= (!is_add && hit) ? hit_value : MISS_VALUE;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lkvc_port_checker.sv @@
// Port-level checker for the LRU key/value cache and its bind to the top level.
// Depends on lkvc_pkg and on lru_key_value_cache_unit.
`default_nettype none

module lkvc_port_checker
   import lkvc_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_found,
   input wire logic signed [DATA_W-1:0] rsp_value_out
);

   // Items accepted but not yet delivered; the cache holds at most two
   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Drop any result after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Hold a stalled result and its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_value_out))
      else $error("stalled result changed");

   // Miss results, add misses among them, carry the all-ones value
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_value_out == MISS_VALUE)
      else $error("miss result without all-ones value");

   // Stall the input only behind a full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && pending_ff == 2'd2)
      else $error("input stalled without a waiting result");

   // Show no result that no accepted item caused
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an accepted item");

endmodule

bind lru_key_value_cache_unit lkvc_port_checker u_lkvc_port_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_found     (rsp_found),
   .rsp_value_out (rsp_value_out)
);

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for lru_key_value_cache_unit: directed table, then random
// get/add traffic under several capacities, checked against an in-bench LRU predictor.
// Depends on rtl/lkvc_pkg.sv and rtl/lru_key_value_cache_unit.sv.
`timescale 1ns / 1ps

module tb;
   import lkvc_pkg::*;

   localparam int ENTRIES         = 16;
   localparam int PERIOD          = 20;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_CYCLES     = 80;
   localparam int ITEMS_PER_PHASE = 117;
   localparam int REPORT_LIMIT    = 10;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] value;
   } lookup_result_type;

   typedef enum bit {ROW_ITEM, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              op;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] data;
      bit                typed;
      logic              exp_found;
      logic [DATA_W-1:0] exp_value;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 29;

   // Directed table: extremes, hit with value all ones, update of a present key,
   // capacity lowered below occupancy, capacity zero, capacity above ENTRIES
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_ITEM, OP_GET, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_ITEM, OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_ITEM, OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_ITEM, OP_ADD, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, MISS_VALUE},
      '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_ITEM, OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ROW_CAPACITY, OP_GET, 32'h0, 32'd2, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_ADD, 32'h0000_0001, 32'd11, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_ADD, 32'h0000_0002, 32'd22, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_GET, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_CAPACITY, OP_GET, 32'h0, 32'd0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_ADD, 32'h0000_0003, 32'd33, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_GET, 32'h0000_0003, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_GET, 32'h0000_0002, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_CAPACITY, OP_GET, 32'h0, 32'd31, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_ADD, 32'h0000_0000, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_GET, 32'h0000_0003, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_CAPACITY, OP_GET, 32'h0, 32'd1, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_ADD, 32'h0000_0000, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_ADD, 32'h0000_0004, 32'd44, 1'b0, 1'b0, 32'h0},
      '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_CAPACITY, OP_GET, 32'h0, 32'(CAPACITY_RESET), 1'b0, 1'b0, 32'h0}
   };

   // Capacity for each random phase: three idle modes of four phases each
   localparam int PHASES = 12;
   int capacity_plan [PHASES] = '{1, 16, 4, 31, 0, 2, 16, 7, 8, 1, 31, 3};

   localparam logic [DATA_W-1:0] CORNER_WORDS [4] =
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

   // DUT ports; the inputs are all known from time zero
   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              csr_wr_en     = 1'b0;
   logic [CSR_W-1:0]  csr_wr_data   = '0;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic              req_operation = OP_GET;
   logic [DATA_W-1:0] req_key       = '0;
   logic [DATA_W-1:0] req_value_in  = '0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic              rsp_found;
   logic [DATA_W-1:0] rsp_value_out;

   // Predictor state
   logic [DATA_W-1:0] model_key   [ENTRIES] = '{default: '0};
   logic [DATA_W-1:0] model_value [ENTRIES] = '{default: '0};
   bit                model_used  [ENTRIES] = '{default: 1'b0};
   logic [3:0]        model_rank  [ENTRIES] = '{default: '0};
   logic [4:0]        model_fill            = '0;
   logic [CSR_W-1:0]  model_capacity        = CAPACITY_RESET;

   lookup_result_type pending_lookups [$];
   logic [DATA_W-1:0] key_pool [$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                send_idle_pct  = 0;
   int                rsp_idle_pct   = 0;
   bit                hold_armed     = 1'b0;
   bit                hold_taken     = 1'b0;
   int                hold_left      = 0;

   lru_key_value_cache_unit #(.ENTRIES(ENTRIES)) DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key       (req_key),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_value_out (rsp_value_out)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Apply one item to the predictor store and return its result
   function automatic lookup_result_type predict_lookup(logic op, logic [DATA_W-1:0] key,
                                                        logic [DATA_W-1:0] data);
      lookup_result_type res;
      int                hit;
      int                victim;
      int                limit;
      logic [3:0]        old_rank;
      logic [3:0]        oldest;
      hit    = -1;
      victim = -1;
      oldest = '0;
      for (int i = 0; i < ENTRIES; i++)
         if (hit < 0 && model_used[i] && model_key[i] == key) hit = i;
      res.found = (hit >= 0);
      res.value = MISS_VALUE;
      if (hit >= 0) begin
         if (op == OP_GET) res.value = model_value[hit];
         else model_value[hit] = data;
         // promote the hit entry, age the ones that were more recent
         old_rank = model_rank[hit];
         for (int i = 0; i < ENTRIES; i++)
            if (model_used[i] && model_rank[i] < old_rank)
               model_rank[i] = model_rank[i] + 4'd1;
         model_rank[hit] = '0;
      end else if (op == OP_ADD) begin
         limit = (model_capacity == 0) ? 1 :
                 (model_capacity > ENTRIES) ? ENTRIES : int'(model_capacity);
         // evict the least recent entry once the store is at capacity
         if (model_fill >= limit) begin
            for (int i = 0; i < ENTRIES; i++)
               if (model_used[i] && (victim < 0 || model_rank[i] > oldest)) begin
                  victim = i;
                  oldest = model_rank[i];
               end
            if (victim >= 0) begin
               model_used[victim] = 1'b0;
               model_fill = model_fill - 5'd1;
            end
         end
         if (victim < 0)
            for (int i = 0; i < ENTRIES; i++)
               if (victim < 0 && !model_used[i]) victim = i;
         for (int i = 0; i < ENTRIES; i++)
            if (model_used[i]) model_rank[i] = model_rank[i] + 4'd1;
         model_key[victim]   = key;
         model_value[victim] = data;
         model_used[victim]  = 1'b1;
         model_rank[victim]  = '0;
         model_fill = model_fill + 5'd1;
      end
      return res;
   endfunction

   // Offer one item, wait for acceptance, queue what it should return
   task automatic send_item(logic op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] data,
                            bit typed, lookup_result_type typed_res);
      lookup_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid     <= 1'b0;
         req_operation <= 1'($urandom_range(0, 1));
         req_key       <= $urandom;
         req_value_in  <= $urandom;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_value_in  <= data;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      res = predict_lookup(op, key, data);
      pending_lookups.push_back(typed ? typed_res : res);
   endtask

   // Stop offering and wait until every expected result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CSR_W-1:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_capacity = cap;
   endtask

   // Receiver: random stall, plus one long hold-off when armed
   always @(posedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      lookup_result_type exp_res;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result found=%b value_out=%h",
                        $realtime, rsp_found, rsp_value_out);
         end else begin
            exp_res = pending_lookups.pop_front();
            if (rsp_found !== exp_res.found || rsp_value_out !== exp_res.value) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: mismatch found exp %b got %b, value_out exp %h got %h",
                           $realtime, exp_res.found, rsp_found, exp_res.value,
                           rsp_value_out);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic              op;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] data;
      int                limit;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CAPACITY) begin
            drain_results();
            write_capacity(directed_rows[r].data[CSR_W-1:0]);
         end else begin
            send_item(directed_rows[r].op, directed_rows[r].key, directed_rows[r].data,
                      directed_rows[r].typed,
                      lookup_result_type'{found: directed_rows[r].exp_found,
                                          value: directed_rows[r].exp_value});
         end
      end

      // Random phases: receiver-heavy idling, sender-heavy idling, then none
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p / 4)
            0: begin
               send_idle_pct = 29;
               rsp_idle_pct <= 82;
            end
            1: begin
               send_idle_pct = 82;
               rsp_idle_pct <= 29;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         write_capacity(CSR_W'(capacity_plan[p]));
         // build a key pool a little larger than the capacity so hits and evictions mix
         limit = (capacity_plan[p] == 0) ? 1 :
                 (capacity_plan[p] > ENTRIES) ? ENTRIES : capacity_plan[p];
         key_pool.delete();
         repeat (limit + $urandom_range(1, 6))
            key_pool.push_back(($urandom_range(0, 7) == 0) ?
                               CORNER_WORDS[$urandom_range(0, 3)] : $urandom);
         // fill the pipe against a long receiver hold-off
         if (p == 9) hold_armed <= 1'b1;
         repeat (ITEMS_PER_PHASE) begin
            op   = 1'($urandom_range(0, 1));
            key  = ($urandom_range(0, 99) < 85) ?
                   key_pool[$urandom_range(0, key_pool.size() - 1)] : $urandom;
            data = ($urandom_range(0, 4) == 0) ? CORNER_WORDS[$urandom_range(0, 3)] : $urandom;
            send_item(op, key, data, 1'b0, '0);
         end
      end

      drain_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_lookups.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
